// ----- hw/rtl/spo2re_pkg.sv -----
package spo2re_pkg;

    // Configuration port
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_LINE_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESENCE  = 2'd0,
        REG_INTERCEPT = 2'd1,
        REG_SLOPE     = 2'd2
    } cfg_reg_t;

    // Register reset values (levels in whole percent, scaled by the fraction bits)
    localparam int THRESH_RESET  = 50000;
    localparam int INTERCEPT_PCT = 110;
    localparam int SLOPE_PCT     = 25;
    localparam int SMOOTH_PCT    = 98;

    // Clamp limits
    localparam int HI_PCT     = 100;
    localparam int LOW_PCT    = 70;
    localparam int TOP_PERMIL = 999;

    // Exponential average: new = old + W_NEW * (x - old) / 2^SHIFT, rounded
    localparam int EMA_SHIFT = 16;
    localparam int EMA_W_NEW = 3277;

    // Ratio quotient saturates at 2^Q_BITS
    localparam int Q_BITS = 40;

    // Multiplier digit width per step
    localparam int MUL_DIGIT = 8;

endpackage

// ----- hw/rtl/spo2re_ema.sv -----
module spo2re_ema #(
    parameter int W = 26
) (
    input  logic [W-1:0] old_val,
    input  logic [W-1:0] new_val,
    output logic [W-1:0] avg_val
);
    import spo2re_pkg::*;

    localparam int SW = W + EMA_SHIFT + 2;

    logic signed [SW-1:0] diff;
    logic signed [SW-1:0] sum;

    // 62259*old + 3277*x is rewritten as old*2^16 + 3277*(x - old).
    always_comb begin
        diff = $signed(SW'(new_val)) - $signed(SW'(old_val));
        sum  = $signed({2'b00, old_val, {EMA_SHIFT{1'b0}}})
             + diff * $signed(SW'(EMA_W_NEW))
             + $signed(SW'(1 << (EMA_SHIFT - 1)));
    end

    assign avg_val = sum[EMA_SHIFT +: W];

endmodule

// ----- hw/rtl/spo2re_mul.sv -----
module spo2re_mul #(
    parameter int W = 26
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   op_a,
    input  logic [W-1:0]   op_b,
    output logic           done,
    output logic [2*W-1:0] product
);
    import spo2re_pkg::*;

    localparam int NS = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BW = NS * MUL_DIGIT;
    localparam int CW = $clog2(NS + 1);

    logic [W-1:0]           a_reg;
    logic [BW-1:0]          b_reg;
    logic [2*W-1:0]         acc_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [W+MUL_DIGIT-1:0] partial;

    // One digit of the multiplier per cycle, most significant digit first.
    assign partial = a_reg * b_reg[BW-1 -: MUL_DIGIT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= BW'(op_b);
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= (acc_reg << MUL_DIGIT) + (2*W)'(partial);
            b_reg   <= b_reg << MUL_DIGIT;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hw/rtl/spo2re_div.sv -----
module spo2re_div #(
    parameter int NW = 60,
    parameter int DW = 52
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [NW-1:0]                   dividend,
    input  logic [DW-1:0]                   divisor,
    output logic                            done,
    output logic [spo2re_pkg::Q_BITS:0]     quotient
);
    import spo2re_pkg::*;

    localparam int RW = DW + 1;
    localparam int XW = NW + Q_BITS;
    localparam int CW = $clog2(Q_BITS + 1);

    logic [XW-1:0]     ext;
    logic [XW-1:0]     lim;
    logic              sat;
    logic [RW-1:0]     rem_reg;
    logic [Q_BITS-1:0] low_reg;
    logic [Q_BITS-1:0] q_reg;
    logic [DW-1:0]     div_reg;
    logic              sat_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [RW-1:0]     trial;
    logic              fits;

    // The quotient reaches 2^Q_BITS exactly when dividend >= divisor * 2^Q_BITS.
    // Otherwise the high part of the dividend is already below the divisor and
    // only Q_BITS quotient bits remain to be found.
    assign ext   = XW'(dividend);
    assign lim   = XW'({divisor, {Q_BITS{1'b0}}});
    assign sat   = ext >= lim;
    assign trial = {rem_reg[RW-2:0], low_reg[Q_BITS-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !sat;
                done_reg <= sat;
                cnt_reg  <= CW'(Q_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sat_reg <= sat;
            div_reg <= divisor;
            rem_reg <= ext[Q_BITS +: RW];
            low_reg <= ext[Q_BITS-1:0];
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
            low_reg <= low_reg << 1;
            q_reg   <= {q_reg[Q_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? {1'b1, {Q_BITS{1'b0}}} : {1'b0, q_reg};

endmodule

// ----- hw/rtl/spo2_ratio_estimator.sv -----
// SpO2 ratio-of-ratios estimator.
//
// The input stream carries one red and one infrared photodiode sample per
// transfer. Every accepted transfer produces exactly one result transfer on
// the output stream: the smoothed saturation level in m_tdata and the
// no-contact flag in m_tuser. Three configuration registers (presence
// threshold, line intercept, line slope) sit on the plain write port, and the
// user must write them only while the block is idle (not enforced); no read-back.
//
// The block works on one sample pair at a time and drops s_tready while busy.
// A full computation runs the two products on the shared 8-bit-per-cycle
// multiplier, numerator first, and then the 40-step restoring divider; the
// next pair is taken only once the block is back in idle. A missing finger
// goes straight from the accepted transfer to the result, a zero denominator
// skips the divider, and a saturated ratio skips the divider steps.
//
// Reset restores the register defaults, clears both baselines and sets the
// smoothed level to 98 percent. A stalled receiver holds the result in the
// output register; a new pair may be accepted meanwhile and waits at the end.
module spo2_ratio_estimator #(
    parameter int SAMPLE_BITS = 18,
    parameter int FRAC_BITS   = 8
) (
    input  logic aclk,
    input  logic aresetn,

    // s_tdata fields from bit 0: red_sample, ir_sample
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]             s_tdata,

    // m_tdata fields from bit 0: spo2_level
    // m_tuser fields from bit 0: no_contact
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    output logic [((FRAC_BITS+7+7)/8)*8-1:0]               m_tdata,
    output logic [0:0]                                     m_tuser,

    input  logic                                           cfg_we,
    input  logic [spo2re_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [spo2re_pkg::CFG_W-1:0]                   cfg_wdata
);
    import spo2re_pkg::*;

    localparam int VB    = SAMPLE_BITS + FRAC_BITS;
    localparam int LW    = FRAC_BITS + 7;
    localparam int INT_W = (FRAC_BITS + 7 > CFG_LINE_W) ? FRAC_BITS + 7 : CFG_LINE_W;
    localparam int SLP_W = (FRAC_BITS + 5 > CFG_LINE_W) ? FRAC_BITS + 5 : CFG_LINE_W;
    localparam int TH_W  = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
    localparam int MDW   = ((LW + 7) / 8) * 8;
    localparam int NUMW  = 2 * VB;
    localparam int DVDW  = NUMW + FRAC_BITS;
    localparam int QW    = Q_BITS + 1;
    localparam int PW    = SLP_W + QW;
    localparam int RAW_W = PW + 2;

    localparam int HI_LIM  = HI_PCT << FRAC_BITS;
    localparam int TOP_LVL = (TOP_PERMIL << FRAC_BITS) / 10;
    localparam int LOW_LVL = LOW_PCT << FRAC_BITS;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_BASE_R  = 11'b000_0000_0010,
        ST_BASE_I  = 11'b000_0000_0100,
        ST_AC      = 11'b000_0000_1000,
        ST_MUL_NUM = 11'b000_0001_0000,
        ST_MUL_DEN = 11'b000_0010_0000,
        ST_CHECK   = 11'b000_0100_0000,
        ST_DIV     = 11'b000_1000_0000,
        ST_RAW     = 11'b001_0000_0000,
        ST_SMOOTH  = 11'b010_0000_0000,
        ST_WRITE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [CFG_W-1:0] thresh_reg;
    logic [INT_W-1:0] icpt_reg;
    logic [SLP_W-1:0] slope_reg;

    // Filter state
    logic [VB-1:0] red_base_reg;
    logic [VB-1:0] ir_base_reg;
    logic [LW-1:0] smooth_reg;

    // Per-sample working registers
    logic [SAMPLE_BITS-1:0] red_reg;
    logic [SAMPLE_BITS-1:0] ir_reg;
    logic [VB-1:0]          mag_i_reg;
    logic                   neg_r_reg;
    logic                   neg_reg;
    logic [NUMW-1:0]        num_reg;
    logic [PW-1:0]          prod_reg;
    logic [LW-1:0]          raw_reg;
    logic [LW-1:0]          res_level_reg;
    logic                   res_flag_reg;

    // Output register
    logic          m_valid_reg;
    logic [LW-1:0] m_level_reg;
    logic          m_flag_reg;

    logic                   s_accept;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] s_red;
    logic [SAMPLE_BITS-1:0] s_ir;
    logic                   s_absent;
    logic [VB-1:0]          xr;
    logic [VB-1:0]          xi;
    logic                   neg_r;
    logic                   neg_i;
    logic [VB-1:0]          mag_r;
    logic [VB-1:0]          mag_i;

    logic [VB-1:0]   ema_old;
    logic [VB-1:0]   ema_new;
    logic [VB-1:0]   ema_avg;

    logic            mul_start;
    logic [VB-1:0]   mul_a;
    logic [VB-1:0]   mul_b;
    logic            mul_done;
    logic [NUMW-1:0] mul_p;

    logic            div_start;
    logic            div_done;
    logic [QW-1:0]   div_q;

    logic [PW-1:0]           term;
    logic signed [RAW_W-1:0] raw_s;
    logic [LW-1:0]           raw_clamped;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign s_red    = s_tdata[SAMPLE_BITS-1:0];
    assign s_ir     = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign s_absent = TH_W'(s_ir) < TH_W'(thresh_reg);

    // Samples scaled to the fixed-point level format.
    assign xr = {red_reg, {FRAC_BITS{1'b0}}};
    assign xi = {ir_reg, {FRAC_BITS{1'b0}}};

    // AC parts as sign and magnitude against the updated baselines.
    assign neg_r = xr < red_base_reg;
    assign neg_i = xi < ir_base_reg;
    assign mag_r = neg_r ? (red_base_reg - xr) : (xr - red_base_reg);
    assign mag_i = neg_i ? (ir_base_reg - xi) : (xi - ir_base_reg);

    // The averaging unit serves both baselines and the level smoother. A
    // baseline that is still zero starts from the sample itself.
    always_comb begin
        case (state_reg)
            ST_BASE_R: begin
                ema_old = (red_base_reg == '0) ? xr : red_base_reg;
                ema_new = xr;
            end
            ST_BASE_I: begin
                ema_old = (ir_base_reg == '0) ? xi : ir_base_reg;
                ema_new = xi;
            end
            default: begin
                ema_old = VB'(smooth_reg);
                ema_new = VB'(raw_reg);
            end
        endcase
    end

    spo2re_ema #(
        .W(VB)
    ) u_ema (
        .old_val(ema_old),
        .new_val(ema_new),
        .avg_val(ema_avg)
    );

    // The multiplier first forms the numerator |ac_red| * dc_ir, then the
    // denominator |ac_ir| * dc_red.
    assign mul_start = (state_reg == ST_AC) || (state_reg == ST_MUL_NUM && mul_done);
    assign mul_a     = (state_reg == ST_AC) ? mag_r : mag_i_reg;
    assign mul_b     = (state_reg == ST_AC) ? ir_base_reg : red_base_reg;

    spo2re_mul #(
        .W(VB)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .product(mul_p)
    );

    // The denominator still sits in the multiplier's accumulator here.
    assign div_start = (state_reg == ST_CHECK) && (mul_p != '0);

    spo2re_div #(
        .NW(DVDW),
        .DW(NUMW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend({num_reg, {FRAC_BITS{1'b0}}}),
        .divisor (mul_p),
        .done    (div_done),
        .quotient(div_q)
    );

    // Raw level from the line, then clamped: below 70 percent to 70, above 100 percent to 99.9.
    assign term = prod_reg >> FRAC_BITS;

    always_comb begin
        if (neg_reg) begin
            raw_s = $signed(RAW_W'(icpt_reg)) + $signed(RAW_W'(term));
        end else begin
            raw_s = $signed(RAW_W'(icpt_reg)) - $signed(RAW_W'(term));
        end
        if (raw_s > RAW_W'(HI_LIM)) begin
            raw_clamped = LW'(TOP_LVL);
        end else if (raw_s < RAW_W'(LOW_LVL)) begin
            raw_clamped = LW'(LOW_LVL);
        end else begin
            raw_clamped = raw_s[LW-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = s_absent ? ST_WRITE : ST_BASE_R;
                end
            end
            ST_BASE_R:  state_next = ST_BASE_I;
            ST_BASE_I:  state_next = ST_AC;
            ST_AC:      state_next = ST_MUL_NUM;
            ST_MUL_NUM: begin
                if (mul_done) begin
                    state_next = ST_MUL_DEN;
                end
            end
            ST_MUL_DEN: begin
                if (mul_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (mul_p != '0) begin
                    state_next = ST_DIV;
                end else if (num_reg == '0) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_SMOOTH;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_RAW;
                end
            end
            ST_RAW:    state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_WRITE;
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and filter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            thresh_reg   <= CFG_W'(THRESH_RESET);
            icpt_reg     <= INT_W'(INTERCEPT_PCT << FRAC_BITS);
            slope_reg    <= SLP_W'(SLOPE_PCT << FRAC_BITS);
            red_base_reg <= '0;
            ir_base_reg  <= '0;
            smooth_reg   <= LW'(SMOOTH_PCT << FRAC_BITS);
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    REG_PRESENCE:  thresh_reg <= cfg_wdata;
                    REG_INTERCEPT: icpt_reg   <= INT_W'(cfg_wdata[CFG_LINE_W-1:0]);
                    REG_SLOPE:     slope_reg  <= SLP_W'(cfg_wdata[CFG_LINE_W-1:0]);
                    default: ;
                endcase
            end

            if (state_reg == ST_BASE_R) begin
                red_base_reg <= ema_avg;
            end
            if (state_reg == ST_BASE_I) begin
                ir_base_reg <= ema_avg;
            end
            if (state_reg == ST_SMOOTH) begin
                smooth_reg <= ema_avg[LW-1:0];
            end

            if (state_reg == ST_WRITE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    red_reg       <= s_red;
                    ir_reg        <= s_ir;
                    res_level_reg <= '0;
                    res_flag_reg  <= s_absent;
                end
            end
            ST_AC: begin
                mag_i_reg <= mag_i;
                neg_r_reg <= neg_r;
                neg_reg   <= neg_r ^ neg_i;
            end
            ST_MUL_NUM: begin
                if (mul_done) begin
                    num_reg <= mul_p;
                end
            end
            ST_CHECK: begin
                // A zero denominator pins the raw level to one end of the band;
                // zero over zero reports the smoothed level untouched.
                raw_reg       <= neg_r_reg ? LW'(TOP_LVL) : LW'(LOW_LVL);
                res_level_reg <= smooth_reg;
                res_flag_reg  <= 1'b0;
            end
            ST_DIV: begin
                if (div_done) begin
                    prod_reg <= slope_reg * div_q;
                end
            end
            ST_RAW: begin
                raw_reg <= raw_clamped;
            end
            ST_SMOOTH: begin
                res_level_reg <= ema_avg[LW-1:0];
                res_flag_reg  <= 1'b0;
            end
            ST_WRITE: begin
                if (out_free) begin
                    m_level_reg <= res_level_reg;
                    m_flag_reg  <= res_flag_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MDW'(m_level_reg);
    assign m_tuser  = m_flag_reg;

endmodule
